>>> src/paids_pkg.sv
package paids_pkg;

   localparam int DEPTH_DEF = 128;

   localparam int OP_W    = 3;
   localparam int IDX_W   = 8;
   localparam int VAL_W   = 32;
   localparam int STAT_W  = 3;
   localparam int FOUND_W = 7;
   localparam int COUNT_W = 8;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 3'd0,
      OP_INSERT = 3'd1,
      OP_DELETE = 3'd2,
      OP_SEARCH = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_OVERFLOW  = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_BAD_INDEX = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SHIFT_UP,
      S_DRAIN_UP,
      S_WRITE_NEW,
      S_DEL_FETCH,
      S_DEL_TAKE,
      S_SHIFT_DOWN,
      S_DRAIN_DOWN,
      S_DEL_DONE,
      S_SCAN,
      S_RD_FETCH,
      S_RD_TAKE,
      S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_IDX,
      PTR_LAST,
      PTR_ZERO,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   typedef struct packed {
      logic       load_req;
      logic       count_clear;
      logic       count_inc;
      logic       count_dec;
      ptr_op_type ptr_op;
      logic       rd_en;
      logic       wr_shift;
      logic       shift_up;
      logic       wr_new;
      logic       set_status;
      status_type status;
      logic       take_data;
      logic       take_found;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            empty;
      logic            idx_gt_cnt;
      logic            idx_ge_cnt;
      logic            idx_eq_cnt;
      logic            ptr_eq_idx;
      logic            ptr_eq_last;
      logic            ptr_eq_count;
      logic            ptr_lt_count;
      logic            rvalid;
      logic            hit;
      logic            cmp_last;
   } stat_type;

endpackage

>>> src/paids_ctrl.sv
module paids_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  paids_pkg::stat_type stat,
   output paids_pkg::cmd_type  cmd
);
   import paids_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == S_FINISH && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            unique case (stat.op)
               OP_INSERT: begin
                  if (stat.full || stat.idx_gt_cnt) state_in = S_FINISH;
                  else if (stat.idx_eq_cnt)         state_in = S_WRITE_NEW;
                  else                              state_in = S_SHIFT_UP;
               end
               OP_DELETE: begin
                  if (stat.empty || stat.idx_ge_cnt) state_in = S_FINISH;
                  else                               state_in = S_DEL_FETCH;
               end
               OP_SEARCH: begin
                  if (stat.empty) state_in = S_FINISH;
                  else            state_in = S_SCAN;
               end
               OP_READ: begin
                  if (stat.empty || stat.idx_ge_cnt) state_in = S_FINISH;
                  else                               state_in = S_RD_FETCH;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_SHIFT_UP: begin
            if (stat.ptr_eq_idx) state_in = S_DRAIN_UP;
         end
         S_DRAIN_UP:  state_in = S_WRITE_NEW;
         S_WRITE_NEW: state_in = S_FINISH;
         S_DEL_FETCH: state_in = S_DEL_TAKE;
         S_DEL_TAKE: begin
            if (stat.ptr_eq_count)     state_in = S_DEL_DONE;
            else if (stat.ptr_eq_last) state_in = S_DRAIN_DOWN;
            else                       state_in = S_SHIFT_DOWN;
         end
         S_SHIFT_DOWN: begin
            if (stat.ptr_eq_last) state_in = S_DRAIN_DOWN;
         end
         S_DRAIN_DOWN: state_in = S_DEL_DONE;
         S_DEL_DONE:   state_in = S_FINISH;
         S_SCAN: begin
            if (stat.hit || (stat.rvalid && stat.cmp_last)) state_in = S_FINISH;
         end
         S_RD_FETCH: state_in = S_RD_TAKE;
         S_RD_TAKE:  state_in = S_FINISH;
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.ptr_op = PTR_HOLD;
      cmd.status = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load_req = req_valid;
         end
         S_CHECK: begin
            unique case (stat.op)
               OP_CLEAR: cmd.count_clear = 1'b1;
               OP_INSERT: begin
                  if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_OVERFLOW;
                  end else if (stat.idx_gt_cnt) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_BAD_INDEX;
                  end else if (!stat.idx_eq_cnt) begin
                     cmd.ptr_op = PTR_LAST;
                  end
               end
               OP_DELETE, OP_READ: begin
                  if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else if (stat.idx_ge_cnt) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_BAD_INDEX;
                  end else begin
                     cmd.ptr_op = PTR_IDX;
                  end
               end
               OP_SEARCH: begin
                  if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else begin
                     cmd.ptr_op = PTR_ZERO;
                  end
               end
               default: ;
            endcase
         end
         S_SHIFT_UP: begin
            cmd.rd_en    = 1'b1;
            cmd.ptr_op   = PTR_DEC;
            cmd.wr_shift = stat.rvalid;
            cmd.shift_up = 1'b1;
         end
         S_DRAIN_UP: begin
            cmd.wr_shift = 1'b1;
            cmd.shift_up = 1'b1;
         end
         S_WRITE_NEW: begin
            cmd.wr_new    = 1'b1;
            cmd.count_inc = 1'b1;
         end
         S_DEL_FETCH: begin
            cmd.rd_en  = 1'b1;
            cmd.ptr_op = PTR_INC;
         end
         S_DEL_TAKE: begin
            cmd.take_data = 1'b1;
            if (!stat.ptr_eq_count) begin
               cmd.rd_en  = 1'b1;
               cmd.ptr_op = PTR_INC;
            end
         end
         S_SHIFT_DOWN: begin
            cmd.rd_en    = 1'b1;
            cmd.ptr_op   = PTR_INC;
            cmd.wr_shift = stat.rvalid;
         end
         S_DRAIN_DOWN: begin
            cmd.wr_shift = 1'b1;
         end
         S_DEL_DONE: begin
            cmd.count_dec = 1'b1;
         end
         S_SCAN: begin
            if (stat.hit) begin
               cmd.take_found = 1'b1;
            end else if (stat.rvalid && stat.cmp_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NOT_FOUND;
            end else if (stat.ptr_lt_count) begin
               cmd.rd_en  = 1'b1;
               cmd.ptr_op = PTR_INC;
            end
         end
         S_RD_FETCH: begin
            cmd.rd_en = 1'b1;
         end
         S_RD_TAKE: begin
            cmd.take_data = 1'b1;
         end
         S_FINISH: begin
            cmd.load_rsp = out_free;
         end
         default: ;
      endcase
   end

endmodule

>>> src/paids_dp.sv
module paids_dp #(
   parameter int DEPTH = paids_pkg::DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic        [paids_pkg::OP_W-1:0]     req_operation,
   input  logic        [paids_pkg::IDX_W-1:0]    req_index,
   input  logic signed [paids_pkg::VAL_W-1:0]    req_value,
   output logic        [paids_pkg::STAT_W-1:0]   rsp_status,
   output logic        [paids_pkg::FOUND_W-1:0]  rsp_found_index,
   output logic signed [paids_pkg::VAL_W-1:0]    rsp_data,
   output logic        [paids_pkg::COUNT_W-1:0]  rsp_count,
   input  paids_pkg::cmd_type                    cmd,
   output paids_pkg::stat_type                   stat
);
   import paids_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
   localparam int EW   = (AW > FOUND_W) ? AW : FOUND_W;
   localparam int OW   = (CW > COUNT_W) ? CW : COUNT_W;

   logic [VAL_W-1:0] mem_ff [DEPTH];

   logic [OP_W-1:0]          op_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic signed [VAL_W-1:0]  val_ff;
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            ptr_ff, ptr_in;
   logic [CW-1:0]            cmp_ptr_ff;
   logic                     rvalid_ff;
   logic [VAL_W-1:0]         rdata_ff;

   status_type               res_status_ff;
   logic [FOUND_W-1:0]       res_found_ff;
   logic signed [VAL_W-1:0]  res_data_ff;

   logic [STAT_W-1:0]        rsp_status_ff;
   logic [FOUND_W-1:0]       rsp_found_ff;
   logic signed [VAL_W-1:0]  rsp_data_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;

   logic [CMPW-1:0]          idx_ext;
   logic [CMPW-1:0]          cnt_ext;
   logic [CW-1:0]            idx_c;
   logic [CW-1:0]            last_c;
   logic [CW-1:0]            waddr_c;
   logic [EW-1:0]            found_ext;
   logic [OW-1:0]            count_ext;

   assign idx_ext   = CMPW'(idx_ff);
   assign cnt_ext   = CMPW'(count_ff);
   assign idx_c     = CW'(idx_ext);
   assign last_c    = count_ff - CW'(1);
   assign waddr_c   = cmd.shift_up ? (cmp_ptr_ff + CW'(1)) : (cmp_ptr_ff - CW'(1));
   assign found_ext = EW'(cmp_ptr_ff[AW-1:0]);
   assign count_ext = OW'(count_ff);

   always_comb begin
      stat.op           = op_ff;
      stat.full         = (count_ff == CW'(DEPTH));
      stat.empty        = (count_ff == '0);
      stat.idx_gt_cnt   = (idx_ext > cnt_ext);
      stat.idx_ge_cnt   = (idx_ext >= cnt_ext);
      stat.idx_eq_cnt   = (idx_ext == cnt_ext);
      stat.ptr_eq_idx   = (ptr_ff == idx_c);
      stat.ptr_eq_last  = (ptr_ff == last_c);
      stat.ptr_eq_count = (ptr_ff == count_ff);
      stat.ptr_lt_count = (ptr_ff < count_ff);
      stat.rvalid       = rvalid_ff;
      stat.hit          = rvalid_ff && (rdata_ff == val_ff);
      stat.cmp_last     = (cmp_ptr_ff == last_c);
   end

   always_comb begin
      ptr_in = ptr_ff;
      case (cmd.ptr_op)
         PTR_IDX:  ptr_in = idx_c;
         PTR_LAST: ptr_in = last_c;
         PTR_ZERO: ptr_in = '0;
         PTR_INC:  ptr_in = ptr_ff + CW'(1);
         PTR_DEC:  ptr_in = ptr_ff - CW'(1);
         default:  ptr_in = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_shift) begin
         mem_ff[waddr_c[AW-1:0]] <= rdata_ff;
      end else if (cmd.wr_new) begin
         mem_ff[idx_c[AW-1:0]] <= val_ff;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem_ff[ptr_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= cmd.rd_en;
         if (cmd.count_clear) begin
            count_ff <= '0;
         end else if (cmd.count_inc) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.count_dec) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.rd_en) begin
         cmp_ptr_ff <= ptr_ff;
      end
      if (cmd.load_req) begin
         op_ff         <= req_operation;
         idx_ff        <= req_index;
         val_ff        <= req_value;
         res_status_ff <= ST_OK;
         res_found_ff  <= '0;
         res_data_ff   <= '0;
      end else begin
         if (cmd.set_status) begin
            res_status_ff <= cmd.status;
         end
         if (cmd.take_data) begin
            res_data_ff <= rdata_ff;
         end
         if (cmd.take_found) begin
            res_found_ff <= found_ext[FOUND_W-1:0];
         end
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_data_ff   <= res_data_ff;
         rsp_count_ff  <= count_ext[COUNT_W-1:0];
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_data        = rsp_data_ff;
   assign rsp_count       = rsp_count_ff;

endmodule

>>> src/positional_array_insert_delete_search_unit.sv
// Ordered list of up to DEPTH signed 32-bit values with a fill count.
// Request channel (req_valid / req_stall): operation, index, value. One
// request is in flight at a time; req_stall is high from acceptance until
// its response is registered. Response channel (rsp_valid / rsp_stall):
// status, found_index, data and the count after the operation, exactly
// one response per request, held stable while rsp_stall is high.
// Each operation walks the entry memory: insert shifts the entries from
// the last one down to the index up one place (none when appending),
// delete takes the entry at the index and shifts the entries above it
// down one place, search reads from index 0 and stops at the first
// match, read fetches the entry at the index, and clear and unknown codes
// touch no entry. The next request is taken at the edge that can take
// the response of the last one at the earliest.
// The walk is set by the entry memory: one entry is read and one shifted
// entry is written per cycle.
// Reset empties the list and drops any pending response; stored entries
// are not cleared. A stalled response holds the block in its final step,
// so no new request is taken until the response register can be loaded.
module positional_array_insert_delete_search_unit #(
   parameter int DEPTH = paids_pkg::DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic        [paids_pkg::OP_W-1:0]     req_operation,
   input  logic        [paids_pkg::IDX_W-1:0]    req_index,
   input  logic signed [paids_pkg::VAL_W-1:0]    req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic        [paids_pkg::STAT_W-1:0]   rsp_status,
   output logic        [paids_pkg::FOUND_W-1:0]  rsp_found_index,
   output logic signed [paids_pkg::VAL_W-1:0]    rsp_data,
   output logic        [paids_pkg::COUNT_W-1:0]  rsp_count
);
   import paids_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   paids_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   paids_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_operation   (req_operation),
      .req_index       (req_index),
      .req_value       (req_value),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_data        (rsp_data),
      .rsp_count       (rsp_count),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

>>> src/paids_checker.sv
module paids_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic        [paids_pkg::STAT_W-1:0]   rsp_status,
   input logic        [paids_pkg::FOUND_W-1:0]  rsp_found_index,
   input logic signed [paids_pkg::VAL_W-1:0]    rsp_data,
   input logic        [paids_pkg::COUNT_W-1:0]  rsp_count
);
   import paids_pkg::*;

   a_busy_after_request: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall
   ) else $error("block took a second request without going busy");

   a_rsp_hold: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_data) && $stable(rsp_count))
   ) else $error("stalled response changed");

   a_empty_means_zero: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_count == '0)
   ) else $error("empty status with nonzero count");

   a_error_no_payload: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_data == '0 && rsp_found_index == '0)
   ) else $error("refused request returned data");

endmodule

bind positional_array_insert_delete_search_unit paids_checker u_checker (.*);

>>> bench/paids_list_checker.sv
`timescale 1ns / 100ps

module paids_list_checker #(
   parameter int DEPTH = paids_pkg::DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic        [paids_pkg::OP_W-1:0]     req_operation,
   input  logic        [paids_pkg::IDX_W-1:0]    req_index,
   input  logic signed [paids_pkg::VAL_W-1:0]    req_value,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic        [paids_pkg::STAT_W-1:0]   rsp_status,
   input  logic        [paids_pkg::FOUND_W-1:0]  rsp_found_index,
   input  logic signed [paids_pkg::VAL_W-1:0]    rsp_data,
   input  logic        [paids_pkg::COUNT_W-1:0]  rsp_count,
   output int                                    fail_count,
   output int                                    outstanding
);
   import paids_pkg::*;

   typedef struct packed {
      status_type                status;
      logic        [FOUND_W-1:0] found_index;
      logic signed [VAL_W-1:0]   data;
      logic        [COUNT_W-1:0] count;
   } list_result_type;

   localparam int AW = $clog2(DEPTH);

   logic signed [VAL_W-1:0] entries [DEPTH];
   int                      fill;
   list_result_type         pending_results [$];

   initial begin
      fill = 0;
      fail_count = 0;
      outstanding = 0;
      for (int i = 0; i < DEPTH; i++) begin
         entries[AW'(i)] = '0;
      end
   end

   function automatic list_result_type apply_request(input logic [OP_W-1:0] op,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic signed [VAL_W-1:0] val);
      list_result_type r;
      int              i;
      int              pos;
      bit              hit;
      pos = int'(idx);
      r.status = ST_OK;
      r.found_index = '0;
      r.data = '0;
      hit = 1'b0;
      case (op)
         OP_CLEAR: begin
            fill = 0;
         end
         OP_INSERT: begin
            if (fill >= DEPTH) begin
               r.status = ST_OVERFLOW;
            end else if (pos > fill) begin
               r.status = ST_BAD_INDEX;
            end else begin
               for (i = fill; i > pos; i--) begin
                  entries[AW'(i)] = entries[AW'(i - 1)];
               end
               entries[AW'(pos)] = val;
               fill++;
            end
         end
         OP_DELETE: begin
            if (fill == 0) begin
               r.status = ST_EMPTY;
            end else if (pos >= fill) begin
               r.status = ST_BAD_INDEX;
            end else begin
               r.data = entries[AW'(pos)];
               for (i = pos; i + 1 < fill; i++) begin
                  entries[AW'(i)] = entries[AW'(i + 1)];
               end
               fill--;
            end
         end
         OP_SEARCH: begin
            if (fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.status = ST_NOT_FOUND;
               for (i = 0; i < fill && !hit; i++) begin
                  if (entries[AW'(i)] == val) begin
                     r.status = ST_OK;
                     r.found_index = i[FOUND_W-1:0];
                     hit = 1'b1;
                  end
               end
            end
         end
         OP_READ: begin
            if (fill == 0) begin
               r.status = ST_EMPTY;
            end else if (pos >= fill) begin
               r.status = ST_BAD_INDEX;
            end else begin
               r.data = entries[AW'(pos)];
            end
         end
         default: begin
         end
      endcase
      r.count = fill[COUNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      list_result_type want;
      list_result_type got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pending_results.push_back(apply_request(req_operation, req_index, req_value));
         end
         if (rsp_valid && !rsp_stall) begin
            got.status = status_type'(rsp_status);
            got.found_index = rsp_found_index;
            got.data = rsp_data;
            got.count = rsp_count;
            if (pending_results.size() == 0) begin
               fail_count++;
               $display("%0t: response with no request pending: status %0d",
                        $time, rsp_status, " found_index %0d data %0d count %0d",
                        rsp_found_index, rsp_data, rsp_count);
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  fail_count++;
                  $display("%0t: mismatch (expected/actual) status %0d/%0d",
                           $time, want.status, rsp_status,
                           " found_index %0d/%0d data %0d/%0d count %0d/%0d",
                           want.found_index, rsp_found_index,
                           want.data, rsp_data, want.count, rsp_count);
               end
            end
         end
      end
      outstanding = pending_results.size();
   end

endmodule

>>> bench/positional_array_insert_delete_search_unit_tb.sv
`timescale 1ns / 100ps

module positional_array_insert_delete_search_unit_tb;
   import paids_pkg::*;

   localparam int DEPTH = DEPTH_DEF;
   localparam int ITEMS = 1900;
   localparam int IDLE_PCT = 24;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES = 150;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic        [OP_W-1:0]    req_operation;
   logic        [IDX_W-1:0]   req_index;
   logic signed [VAL_W-1:0]   req_value;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic        [STAT_W-1:0]  rsp_status;
   logic        [FOUND_W-1:0] rsp_found_index;
   logic signed [VAL_W-1:0]   rsp_data;
   logic        [COUNT_W-1:0] rsp_count;

   int                      fail_count;
   int                      outstanding;
   int                      sent;
   int                      list_size;
   int                      quiet_cycles = 0;
   bit                      calm = 1'b0;
   logic signed [VAL_W-1:0] key_pool [8];

   positional_array_insert_delete_search_unit #(.DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_index(req_index),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_found_index(rsp_found_index),
      .rsp_data(rsp_data),
      .rsp_count(rsp_count)
   );

   paids_list_checker #(.DEPTH(DEPTH)) list_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_index(req_index),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_found_index(rsp_found_index),
      .rsp_data(rsp_data),
      .rsp_count(rsp_count),
      .fail_count(fail_count),
      .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99, 0) < IDLE_PCT);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   function automatic logic signed [VAL_W-1:0] pick_value();
      if ($urandom_range(1, 0) == 1) begin
         return key_pool[3'($urandom_range(7, 0))];
      end
      return $urandom();
   endfunction

   function automatic logic [IDX_W-1:0] pick_position(input bit for_insert);
      int limit;
      limit = for_insert ? list_size : list_size - 1;
      if (limit < 0 || limit >= DEPTH) begin
         return IDX_W'($urandom_range(DEPTH, 0));
      end
      if ($urandom_range(9, 0) == 0) begin
         return IDX_W'($urandom_range(DEPTH, limit + 1));
      end
      return IDX_W'($urandom_range(limit, 0));
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                               input logic signed [VAL_W-1:0] val);
      calm = (sent >= 800 && sent < 1100);
      while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_operation <= op;
      req_index <= idx;
      req_value <= val;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sent++;
      case (op)
         OP_CLEAR: list_size = 0;
         OP_INSERT: if (list_size < DEPTH && int'(idx) <= list_size) list_size++;
         OP_DELETE: if (list_size > 0 && int'(idx) < list_size) list_size--;
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   // hold off new requests until every response is back
   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   task automatic load_list(input int n);
      send_request(OP_CLEAR, IDX_W'($urandom_range(DEPTH, 0)), $urandom());
      for (int k = 0; k < n; k++) begin
         send_request(OP_INSERT, IDX_W'(list_size), pick_value());
      end
   endtask

   initial begin
      int kind;
      int r;
      int ins_w;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_CLEAR;
      req_index = '0;
      req_value = '0;
      sent = 0;
      list_size = 0;
      key_pool[0] = 32'sh8000_0000;
      key_pool[1] = 32'sh7fff_ffff;
      key_pool[2] = 32'sh0000_0000;
      key_pool[3] = -32'sd1;
      key_pool[4] = 32'sd1;
      for (int k = 5; k < 8; k++) begin
         key_pool[3'(k)] = $urandom();
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(OP_SEARCH, 8'd0, 32'sd5);
      send_request(OP_DELETE, 8'd0, 32'sd0);
      send_request(OP_READ, 8'd0, 32'sd0);
      send_request(OP_INSERT, 8'd1, 32'sd9);
      send_request(OP_INSERT, 8'd0, 32'sh8000_0000);
      send_request(OP_INSERT, 8'd1, 32'sh7fff_ffff);
      send_request(OP_INSERT, 8'd0, -32'sd1);
      send_request(OP_INSERT, 8'd3, 32'sh7fff_ffff);
      send_request(OP_SEARCH, 8'd0, 32'sh7fff_ffff);
      send_request(OP_SEARCH, 8'd0, 32'sd12345);
      send_request(OP_READ, 8'd0, 32'sd0);
      send_request(OP_READ, 8'd3, 32'sd0);
      send_request(OP_READ, 8'd4, 32'sd0);
      send_request(OP_DELETE, 8'd4, 32'sd0);
      send_request(OP_DELETE, 8'd128, 32'sd0);
      send_request(OP_INSERT, 8'd128, 32'sd7);
      send_request(OP_DELETE, 8'd1, 32'sd0);
      send_request(3'd5, 8'd128, 32'sh8000_0000);
      send_request(3'd6, 8'd0, 32'sh7fff_ffff);
      send_request(3'd7, 8'd1, -32'sd1);
      send_request(OP_CLEAR, 8'd0, 32'sd0);
      send_request(OP_READ, 8'd0, 32'sd0);
      wait_quiet();

      // fill to capacity, then push past it
      load_list(DEPTH);
      send_request(OP_INSERT, 8'd128, pick_value());
      send_request(OP_INSERT, 8'd0, pick_value());
      send_request(OP_INSERT, IDX_W'($urandom_range(DEPTH, 0)), pick_value());
      send_request(OP_SEARCH, 8'd0, pick_value());

      while (sent < ITEMS + 25) begin
         kind = $urandom_range(99, 0);
         if (kind < 20) begin
            load_list(($urandom_range(7, 0) == 0) ? DEPTH : $urandom_range(40, 0));
            if (list_size == DEPTH) begin
               send_request(OP_INSERT, pick_position(1'b1), pick_value());
            end
         end else if (kind < 75) begin
            for (int k = 0; k < 40; k++) begin
               r = $urandom_range(99, 0);
               ins_w = (list_size < 64) ? 45 : 28;
               if (r < 2) begin
                  send_request(OP_CLEAR, IDX_W'($urandom_range(DEPTH, 0)), $urandom());
               end else if (r < 4) begin
                  send_request(OP_W'($urandom_range(7, 5)), IDX_W'($urandom_range(DEPTH, 0)),
                               $urandom());
               end else if (r < 4 + ins_w) begin
                  send_request(OP_INSERT, pick_position(1'b1), pick_value());
               end else if (r < 28 + ins_w) begin
                  send_request(OP_DELETE, pick_position(1'b0), $urandom());
               end else if (r < 48 + ins_w) begin
                  send_request(OP_SEARCH, IDX_W'($urandom_range(DEPTH, 0)), pick_value());
               end else begin
                  send_request(OP_READ, pick_position(1'b0), $urandom());
               end
            end
         end else if (kind < 90) begin
            while (list_size > 0) begin
               send_request(OP_DELETE, pick_position(1'b0), $urandom());
            end
            send_request(OP_DELETE, IDX_W'($urandom_range(DEPTH, 0)), $urandom());
            send_request(OP_SEARCH, IDX_W'($urandom_range(DEPTH, 0)), pick_value());
            send_request(OP_READ, IDX_W'($urandom_range(DEPTH, 0)), $urandom());
         end else begin
            wait_quiet();
         end
      end

      wait_quiet();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> sim.f
src/paids_pkg.sv
src/paids_ctrl.sv
src/paids_dp.sv
src/positional_array_insert_delete_search_unit.sv
src/paids_checker.sv
bench/paids_list_checker.sv
bench/positional_array_insert_delete_search_unit_tb.sv
